[rtl/rav_pkg.sv]
// Package: payload structs, op codes, sequencer states and fixed widths for the moving average.
`default_nettype none
package rav_pkg;

  localparam int DATA_W = 16;
  localparam int WL_W   = 6;
  localparam logic [WL_W-1:0] WL_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_TARE_AVG  = 2'd1,
    OP_TARE_LAST = 2'd2
  } op_t;

  typedef struct packed {
    logic        [1:0]        op;
    logic signed [DATA_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic signed [DATA_W-1:0] last_sample;
    logic signed [DATA_W-1:0] tare_base;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_START,
    ST_DIV,
    ST_PUSH
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : rav_pkg
`default_nettype wire

[rtl/rav_ring.sv]
// Sample ring memory: one write port, one registered read port.
`default_nettype none
module rav_ring #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [AW-1:0]                    waddr,
  input  wire logic signed [rav_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]                    raddr,
  output logic signed [rav_pkg::DATA_W-1:0]      rdata
);
  import rav_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : rav_ring
`default_nettype wire

[rtl/rav_div.sv]
// Iterative signed divider: one restoring quotient bit per cycle, truncating toward zero.
`default_nettype none
module rav_div #(
  parameter int DVD_W = 21,
  parameter int DVS_W = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0]        divisor,
  output rav_pkg::div_stat_t           stat,
  output logic signed [DVD_W-1:0]      quotient
);
  import rav_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r,  neg_nxt;
  logic [CW-1:0]    cnt_r,  cnt_nxt;
  logic [DVS_W:0]   rem_r,  rem_nxt;
  logic [DVD_W-1:0] quo_r,  quo_nxt;
  logic [DVS_W-1:0] dvs_r,  dvs_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVD_W-1:0] mag;

  always_comb begin
    mag      = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
    rem_sh   = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[DVD_W-1];
      cnt_nxt  = CW'(DVD_W);
      rem_nxt  = '0;
      quo_nxt  = mag;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = neg_r ? DVD_W'(-quo_r) : DVD_W'(quo_r);
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule : rav_div
`default_nettype wire

[rtl/rolling_average_window_top.sv]
// Top level: moving average with tare, sequencer around the ring memory and the divider.
//
//  channel  | ports                          | transaction
//  ---------+--------------------------------+----------------------------------------
//  in       | in_valid in_ready in_data      | op (add / tare to avg / tare to last) + sample
//  out      | out_valid out_ready out_data   | average, last_sample, tare_base
//  cfg      | cfg_valid cfg_ready cfg_data   | window_length write
//
//  From acceptance a transaction steps through ST_READ, ST_UPD, ST_START, ST_DIV
//  and ST_PUSH to out_valid; the bit-serial divider gives one quotient bit a cycle.
//  in_ready and cfg_ready are high only while the sequencer is idle.
//  A result waits in the output register; the next item is accepted while it waits.
//  rst_n is synchronous; reset empties the ring, zeroes last sample and tare base,
//  and loads window_length with 32. A window write restarts the ring empty.
`default_nettype none
module rolling_average_window_top #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire rav_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output rav_pkg::out_t                  out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [rav_pkg::WL_W-1:0]  cfg_data
);
  import rav_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  // a sum of MAX_WINDOW samples fits DATA_W + IDX_W signed bits
  localparam int SUM_W = DATA_W + IDX_W;

  st_t st_r, st_nxt;

  logic [WL_W-1:0]          wl_r,     wl_nxt;
  logic [IDX_W-1:0]         wp_r,     wp_nxt;
  logic                     filled_r, filled_nxt;
  logic signed [SUM_W-1:0]  sum_r,    sum_nxt;
  logic signed [DATA_W-1:0] last_r,   last_nxt;
  logic signed [DATA_W-1:0] base_r,   base_nxt;
  logic [1:0]               op_r,     op_nxt;
  logic signed [DATA_W-1:0] smp_r,    smp_nxt;
  logic                     ov_r,     ov_nxt;
  out_t                     od_r,     od_nxt;

  logic [CNT_W-1:0]         len;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         wp_inc;
  logic signed [DATA_W-1:0] old_smp;
  logic                     ring_we;
  logic                     div_start;
  div_stat_t                div_stat;
  logic signed [SUM_W-1:0]  quo;
  logic signed [DATA_W-1:0] avg;
  logic                     in_acc;
  logic                     cfg_acc;

  // effective window: clamp the register to 1..MAX_WINDOW
  always_comb begin
    if (wl_r == '0) begin
      len = CNT_W'(1);
    end else if (int'(wl_r) > MAX_WINDOW) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(wl_r);
    end
  end

  assign cnt    = filled_r ? len : CNT_W'(wp_r);
  assign wp_inc = CNT_W'(wp_r) + CNT_W'(1);
  assign avg    = (cnt == '0) ? DATA_W'(0) : quo[DATA_W-1:0];

  assign in_ready  = (st_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (st_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  rav_ring #(
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wp_r),
    .wdata (smp_r),
    .raddr (wp_r),
    .rdata (old_smp)
  );

  rav_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt),
    .stat     (div_stat),
    .quotient (quo)
  );

  always_comb begin
    st_nxt     = st_r;
    wl_nxt     = wl_r;
    wp_nxt     = wp_r;
    filled_nxt = filled_r;
    sum_nxt    = sum_r;
    last_nxt   = last_r;
    base_nxt   = base_r;
    op_nxt     = op_r;
    smp_nxt    = smp_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    ring_we    = 1'b0;
    div_start  = 1'b0;

    // drop the result once the consumer takes it
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          // restart the ring empty; contents, last sample and base stay
          wl_nxt     = cfg_data;
          wp_nxt     = '0;
          filled_nxt = 1'b0;
          sum_nxt    = '0;
        end else if (in_acc) begin
          op_nxt  = in_data.op;
          smp_nxt = in_data.sample;
          st_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        // wait for the registered ring read of the entry about to be overwritten
        st_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (op_r == OP_ADD) begin
          ring_we  = 1'b1;
          last_nxt = smp_r;
          // keep the running sum: add the new sample, drop the one it replaces
          sum_nxt  = sum_r + SUM_W'(smp_r) - (filled_r ? SUM_W'(old_smp) : SUM_W'(0));
          if (wp_inc >= len) begin
            wp_nxt     = '0;
            filled_nxt = 1'b1;
          end else begin
            wp_nxt = wp_inc[IDX_W-1:0];
          end
        end else if (op_r == OP_TARE_LAST) begin
          base_nxt = last_r;
        end
        st_nxt = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        st_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          st_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // hold until the output register is free
        if (!ov_r || out_ready) begin
          ov_nxt             = 1'b1;
          od_nxt.average     = avg;
          od_nxt.last_sample = last_r;
          if (op_r == OP_TARE_AVG) begin
            base_nxt           = avg;
            od_nxt.tare_base   = avg;
          end else begin
            od_nxt.tare_base   = base_r;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      wl_r     <= WL_RESET;
      wp_r     <= '0;
      filled_r <= 1'b0;
      sum_r    <= '0;
      last_r   <= '0;
      base_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      wl_r     <= wl_nxt;
      wp_r     <= wp_nxt;
      filled_r <= filled_nxt;
      sum_r    <= sum_nxt;
      last_r   <= last_nxt;
      base_r   <= base_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    smp_r <= smp_nxt;
    od_r  <= od_nxt;
  end

  a_wp_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(wp_r) < len)
    else $error("write position outside the window");

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!filled_r && wp_r == '0) |-> sum_r == '0)
    else $error("empty ring with nonzero sum");

  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r == ST_READ)
    else $error("accepted transaction did not start the sequencer");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> st_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !cfg_ready)
    else $error("configuration open while dividing");

endmodule : rolling_average_window_top
`default_nettype wire

[verif/rav_average_checker.sv]
// Checker: predicts the moving average reports and compares them with the block's output.
module rav_average_checker #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  rav_pkg::in_t               in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  rav_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [rav_pkg::WL_W-1:0]   cfg_data,
  output int                         err_count,
  output int                         pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  import rav_pkg::*;

  localparam int MAX_REPORTS = 200;

  // Mirror of the block state
  logic signed [DATA_W-1:0] ring_q [MAX_WINDOW];
  int unsigned              wr_pos  = 0;
  bit                       wrapped = 1'b0;
  logic signed [DATA_W-1:0] last_s  = '0;
  logic signed [DATA_W-1:0] base_s  = '0;
  logic [WL_W-1:0]          win_len = WL_RESET;

  out_t expected_reports[$];
  out_t want;

  initial begin
    err_count   = 0;
    pending_cnt = 0;
    foreach (ring_q[i]) ring_q[i] = '0;
  end

  function automatic int unsigned active_len();
    int unsigned n;
    n = win_len;
    if (n < 1) n = 1;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    return n;
  endfunction

  // Exact sum of the filled entries, divided once, truncated toward zero
  function automatic logic signed [DATA_W-1:0] fill_mean();
    int unsigned count;
    int          sum;
    count = wrapped ? active_len() : wr_pos;
    if (count > MAX_WINDOW) count = MAX_WINDOW;
    if (count == 0) return '0;
    sum = 0;
    for (int i = 0; i < count; i++) sum += ring_q[i];
    return 16'(sum / int'(count));
  endfunction

  function automatic out_t predict_report(in_t item);
    int unsigned len;
    int unsigned nxt;
    out_t        rep;
    case (item.op)
      OP_ADD: begin
        len = active_len();
        if (wr_pos >= len) wr_pos = 0;
        last_s         = item.sample;
        ring_q[wr_pos] = item.sample;
        nxt = wr_pos + 1;
        if (nxt >= len) nxt = 0;
        if (nxt == 0) wrapped = 1'b1;
        wr_pos = nxt;
      end
      OP_TARE_AVG:  base_s = fill_mean();
      OP_TARE_LAST: base_s = last_s;
      default: ;
    endcase
    rep.average     = fill_mean();
    rep.last_sample = last_s;
    rep.tare_base   = base_s;
    return rep;
  endfunction

  task automatic flag_field(string name, logic signed [DATA_W-1:0] exp_v,
                            logic signed [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (ring_q[i]) ring_q[i] = '0;
      wr_pos  = 0;
      wrapped = 1'b0;
      last_s  = '0;
      base_s  = '0;
      win_len = WL_RESET;
      expected_reports.delete();
      pending_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: unexpected report: expected none, actual %0d/%0d/%0d", $time,
                     out_data.average, out_data.last_sample, out_data.tare_base);
        end else begin
          want = expected_reports.pop_front();
          flag_field("average", want.average, out_data.average);
          flag_field("last_sample", want.last_sample, out_data.last_sample);
          flag_field("tare_base", want.tare_base, out_data.tare_base);
        end
      end
      // A window write restarts the ring empty but keeps its contents
      if (cfg_valid && cfg_ready) begin
        win_len = cfg_data;
        wr_pos  = 0;
        wrapped = 1'b0;
      end
      if (in_valid && in_ready) expected_reports.push_back(predict_report(in_data));
      pending_cnt <= expected_reports.size();
    end
  end

endmodule

[verif/tb_rolling_average_window_top.sv]
// Testbench top: drives samples, tare requests and window writes into the moving average.
module tb_rolling_average_window_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rav_pkg::*;

  localparam int MAX_WINDOW    = 32;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 4;
  localparam int SEGMENTS      = 6;
  localparam int SEG_ITEMS     = 75;
  // op code the block does not define; it must leave the state alone
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  in_t             in_data   = '0;
  logic            out_ready = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [WL_W-1:0] cfg_data  = '0;
  logic            in_ready;
  logic            out_valid;
  out_t            out_data;
  logic            cfg_ready;

  int err_count;
  int pending_cnt;

  // Receiver behavior, changed by the stimulus with nonblocking writes only
  int rx_stall_pct = 0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  // Sender behavior, private to the stimulus process
  int tx_idle_pct  = 0;
  longint cycle_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rolling_average_window_top #(
    .MAX_WINDOW (MAX_WINDOW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rav_average_checker #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .err_count   (err_count),
    .pending_cnt (pending_cnt)
  );

  // Receiver: a bumped hold_req starts a long hold-off counted here; otherwise
  // stall at random per cycle at the current rate.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: end the run with an error once cycle_cnt reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic in_t make_item(logic [1:0] op, logic signed [DATA_W-1:0] smp);
    in_t item;
    item.op     = op;
    item.sample = smp;
    return item;
  endfunction

  // Bias samples toward the extremes and toward small values around zero,
  // where truncation toward zero shows up.
  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'(int'($urandom_range(40)) - 20);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [1:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return OP_ADD;
    if (r < 75) return OP_TARE_AVG;
    if (r < 90) return OP_TARE_LAST;
    return OP_UNUSED;
  endfunction

  // Offer one transaction and hold it until accepted. Valid stays high on
  // return so back-to-back items never drop and raise it in one step.
  task automatic send_item(in_t item);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      // Long gaps so the pause lands anywhere in the block's work
      gap = $urandom_range(1, 60);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected report has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // Write the window only while the block is idle.
  task automatic write_window(logic [WL_W-1:0] len);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [WL_W-1:0] win;

    // Hold reset, then release it once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset window of 32. Tare on an empty ring, extremes, a sum
    // that truncates, both tares, the unused op, alternating bit patterns.
    send_item(make_item(OP_TARE_AVG, 16'sh1234));
    send_item(make_item(OP_ADD, 16'sh7FFF));
    send_item(make_item(OP_ADD, 16'sh8000));
    send_item(make_item(OP_ADD, -16'sd1));
    send_item(make_item(OP_ADD, 16'sd0));
    send_item(make_item(OP_TARE_AVG, 16'sd0));
    send_item(make_item(OP_TARE_LAST, 16'sd0));
    send_item(make_item(OP_UNUSED, -16'sd1));
    send_item(make_item(OP_ADD, 16'sh5555));
    send_item(make_item(OP_ADD, 16'shAAAA));

    // Single-entry window: every sample wraps at once
    write_window(6'd1);
    send_item(make_item(OP_ADD, 16'sh7FFF));
    send_item(make_item(OP_ADD, 16'sh8000));
    send_item(make_item(OP_TARE_AVG, 16'sd0));
    send_item(make_item(OP_TARE_LAST, 16'sd0));

    // Zero acts as one
    write_window(6'd0);
    send_item(make_item(OP_ADD, 16'sd7));
    send_item(make_item(OP_ADD, -16'sd7));

    // Negative mean that truncates toward zero
    write_window(6'd2);
    send_item(make_item(OP_ADD, -16'sd1));
    send_item(make_item(OP_ADD, -16'sd2));
    send_item(make_item(OP_TARE_AVG, 16'sd0));

    // Above the maximum acts as the maximum
    write_window(6'd63);
    send_item(make_item(OP_ADD, 16'sd100));
    send_item(make_item(OP_UNUSED, 16'sd5));
    write_window(6'd33);
    send_item(make_item(OP_ADD, 16'sh7FFF));

    // Random: no idling, sender idle, receiver stalling, both
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 68; end
        default: begin tx_idle_pct = 34; rx_stall_pct <= 34; end
      endcase
      for (int s = 0; s < SEGMENTS; s++) begin
        case (s)
          0:       win = 6'd32;
          1:       win = 6'($urandom_range(1, 8));
          2:       win = 6'($urandom_range(0, 63));
          3:       win = 6'd1;
          4:       win = (p % 2 == 0) ? 6'd63 : 6'd0;
          default: win = 6'($urandom_range(9, 33));
        endcase
        write_window(win);
        // Block the receiver for a long stretch while items keep coming
        if ((p == 0 && s == 1) || (p == 3 && s == 5)) hold_req <= hold_req + 1;
        for (int i = 0; i < SEG_ITEMS; i++) begin
          // Pause the sender until every report is out, mid-stream
          if (p == 1 && s == 2 && i == SEG_ITEMS / 2) wait_drained();
          send_item(make_item(pick_op(), pick_sample()));
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rav_pkg.sv
rtl/rav_ring.sv
rtl/rav_div.sv
rtl/rolling_average_window_top.sv
verif/rav_average_checker.sv
verif/tb_rolling_average_window_top.sv
